[hdl/cuc_tcd_pkg.sv]
// Shared types and constants for the CUC time code decoder.
`default_nettype none

package cuc_tcd_pkg;

  // Default limits on the P-field octet counts
  localparam int BASIC_OCTETS_MIN_DEF    = 1;
  localparam int BASIC_OCTETS_MAX_DEF    = 7;
  localparam int FRACTION_OCTETS_MAX_DEF = 10;

  localparam int SECONDS_W  = 56;
  localparam int FRACTION_W = 64;

  // Time code identification values that are accepted
  localparam logic [2:0] EPOCH_CCSDS  = 3'd1;
  localparam logic [2:0] EPOCH_AGENCY = 3'd2;

  // Fraction octets beyond this many are consumed but dropped
  localparam logic [3:0] FRAC_KEEP_OCTETS = 4'd8;
  localparam logic [3:0] CONSUMED_SAT     = 4'hF;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_EPOCH  = 3'd2,
    ST_THIRD  = 3'd3,
    ST_FORMAT = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    PH_P1    = 5'b00001,
    PH_P2    = 5'b00010,
    PH_BASIC = 5'b00100,
    PH_FRAC  = 5'b01000,
    PH_DRAIN = 5'b10000
  } phase_t;

  typedef struct packed {
    status_t               status;
    logic [2:0]            epoch_id;
    logic [2:0]            basic_count;
    logic [3:0]            frac_count;
    logic [SECONDS_W-1:0]  seconds;
    logic [FRACTION_W-1:0] fraction;
    logic [3:0]            consumed;
  } result_t;

endpackage

`default_nettype wire

[hdl/cuc_time_code_decoder.sv]
// CCSDS unsegmented time code decoder, one octet per request.
`default_nettype none

// Streams a CCSDS unsegmented (CUC) time code in one octet per input request
// and returns at most one result per code. One octet is taken every clock
// cycle while in_stall is low: the P-field and T-field parse is a single
// register stage (phase, counts and the seconds/fraction accumulators), with
// no bubbles. Results go through a two-entry output queue (output register
// plus skid register); in_stall rises only when both hold a result that the
// sink has not taken, so a stalled sink holds back the input at most one
// result late. The result of the octet that completes a code (or raises an
// error) lands in the output register, or in the skid if the output is held.
// A status other than ok carries all-zero payload fields. After a result,
// octets are dropped until an octet flagged last, which itself is dropped;
// a result on an octet flagged last restarts the parse at once. A code that
// ends early on last reports buffer short. The octet count saturates at 15.
module cuc_time_code_decoder
  import cuc_tcd_pkg::*;
#(
  parameter int BASIC_OCTETS_MIN    = BASIC_OCTETS_MIN_DEF,
  parameter int BASIC_OCTETS_MAX    = BASIC_OCTETS_MAX_DEF,
  parameter int FRACTION_OCTETS_MAX = FRACTION_OCTETS_MAX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input octets
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  in_last,
  // decoded results
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [2:0]                 out_status,
  output logic [2:0]                 out_epoch_id,
  output logic [2:0]                 out_basic_count,
  output logic [3:0]                 out_frac_count,
  output logic [SECONDS_W-1:0]       out_seconds_out,
  output logic [FRACTION_W-1:0]      out_fraction_out,
  output logic [3:0]                 out_consumed_count
);

  // Parse state
  phase_t                phase_r, phase_nxt;
  logic [3:0]            idx_r, idx_nxt;
  logic [2:0]            basic_r, basic_nxt;
  logic [3:0]            frac_r, frac_nxt;
  logic [2:0]            epoch_r, epoch_nxt;
  logic [SECONDS_W-1:0]  seconds_r, seconds_nxt;
  logic [FRACTION_W-1:0] fraction_r, fraction_nxt;
  logic [3:0]            consumed_r, consumed_nxt;

  // Output queue
  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;

  logic    in_acc, out_take, res_valid;
  result_t res;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  // Single-octet parse step
  always_comb begin
    logic       fin;
    status_t    fin_st;
    logic       pdone;
    logic [2:0] id;
    logic [3:0] cnt_inc;

    fin          = 1'b0;
    fin_st       = ST_OK;
    pdone        = 1'b0;
    id           = in_data_byte[6:4];
    cnt_inc      = (consumed_r == CONSUMED_SAT) ? consumed_r : consumed_r + 4'd1;

    phase_nxt    = phase_r;
    idx_nxt      = idx_r;
    basic_nxt    = basic_r;
    frac_nxt     = frac_r;
    epoch_nxt    = epoch_r;
    seconds_nxt  = seconds_r;
    fraction_nxt = fraction_r;
    consumed_nxt = consumed_r;

    unique case (phase_r)
      PH_P1: begin
        if (id != EPOCH_CCSDS && id != EPOCH_AGENCY) begin
          fin    = 1'b1;
          fin_st = ST_EPOCH;
        end else begin
          consumed_nxt = cnt_inc;
          epoch_nxt    = id;
          basic_nxt    = {1'b0, in_data_byte[3:2]} + 3'd1;
          frac_nxt     = {2'b00, in_data_byte[1:0]};
          if (!in_data_byte[7]) begin
            pdone = 1'b1;
          end else if (in_last) begin
            fin    = 1'b1;
            fin_st = ST_SHORT;
          end else begin
            phase_nxt = PH_P2;
          end
        end
      end
      PH_P2: begin
        if (in_data_byte[7]) begin
          fin    = 1'b1;
          fin_st = ST_THIRD;
        end else begin
          consumed_nxt = cnt_inc;
          basic_nxt    = basic_r + {1'b0, in_data_byte[6:5]};
          frac_nxt     = frac_r + {1'b0, in_data_byte[4:2]};
          pdone        = 1'b1;
        end
      end
      PH_BASIC: begin
        consumed_nxt = cnt_inc;
        seconds_nxt  = {seconds_r[SECONDS_W-9:0], in_data_byte};
        idx_nxt      = idx_r + 4'd1;
        if (idx_nxt >= {1'b0, basic_r}) begin
          if (frac_r == 4'd0) begin
            fin    = 1'b1;
            fin_st = ST_OK;
          end else begin
            phase_nxt = PH_FRAC;
            idx_nxt   = 4'd0;
          end
        end
        if (!fin && in_last) begin
          fin    = 1'b1;
          fin_st = ST_SHORT;
        end
      end
      PH_FRAC: begin
        consumed_nxt = cnt_inc;
        if (idx_r < FRAC_KEEP_OCTETS) begin
          fraction_nxt = fraction_r |
                         ({in_data_byte, {(FRACTION_W-8){1'b0}}} >> {idx_r[2:0], 3'b000});
        end
        idx_nxt = idx_r + 4'd1;
        if (idx_nxt >= frac_r) begin
          fin    = 1'b1;
          fin_st = ST_OK;
        end else if (in_last) begin
          fin    = 1'b1;
          fin_st = ST_SHORT;
        end
      end
      PH_DRAIN: begin
        // drop octets until last
      end
      default: begin
        phase_nxt = PH_P1;
      end
    endcase

    // End of P-field: check the counts, then the buffer length
    if (pdone) begin
      if (basic_nxt < 3'(BASIC_OCTETS_MIN) || basic_nxt > 3'(BASIC_OCTETS_MAX) ||
          frac_nxt > 4'(FRACTION_OCTETS_MAX)) begin
        fin    = 1'b1;
        fin_st = ST_FORMAT;
      end else if (in_last) begin
        fin    = 1'b1;
        fin_st = ST_SHORT;
      end else begin
        phase_nxt = PH_BASIC;
        idx_nxt   = 4'd0;
      end
    end

    // Build the result from the updated state
    res        = '0;
    res.status = fin_st;
    if (fin && fin_st == ST_OK) begin
      res.epoch_id    = epoch_nxt;
      res.basic_count = basic_nxt;
      res.frac_count  = frac_nxt;
      res.seconds     = seconds_nxt;
      res.fraction    = fraction_nxt;
      res.consumed    = consumed_nxt;
    end
    res_valid = in_acc && fin;

    // Restart on last, otherwise drain the rest of the buffer
    if (fin && !in_last) begin
      phase_nxt = PH_DRAIN;
    end else if (in_last && (fin || phase_r == PH_DRAIN)) begin
      phase_nxt    = PH_P1;
      idx_nxt      = 4'd0;
      basic_nxt    = 3'd0;
      frac_nxt     = 4'd0;
      epoch_nxt    = 3'd0;
      seconds_nxt  = '0;
      fraction_nxt = '0;
      consumed_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_P1;
      idx_r      <= 4'd0;
      basic_r    <= 3'd0;
      frac_r     <= 4'd0;
      epoch_r    <= 3'd0;
      seconds_r  <= '0;
      fraction_r <= '0;
      consumed_r <= 4'd0;
    end else if (in_acc) begin
      phase_r    <= phase_nxt;
      idx_r      <= idx_nxt;
      basic_r    <= basic_nxt;
      frac_r     <= frac_nxt;
      epoch_r    <= epoch_nxt;
      seconds_r  <= seconds_nxt;
      fraction_r <= fraction_nxt;
      consumed_r <= consumed_nxt;
    end
  end

  // Output register plus skid: advance the skid when the output frees up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (res_valid) begin
        out_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_epoch_id       = out_r.epoch_id;
  assign out_basic_count    = out_r.basic_count;
  assign out_frac_count     = out_r.frac_count;
  assign out_seconds_out    = out_r.seconds;
  assign out_fraction_out   = out_r.fraction;
  assign out_consumed_count = out_r.consumed;

  // The skid only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while the output register is empty");

  // A fresh code always starts from cleared accumulators
  a_p1_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_P1) |-> (seconds_r == '0 && fraction_r == '0 && consumed_r == 4'd0))
    else $error("accumulators not cleared at start of code");

  // Basic octet index stays below the basic count
  a_basic_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BASIC) |-> (idx_r < {1'b0, basic_r}))
    else $error("basic octet index overran the basic count");

  // Error results carry a zero payload
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_OK) |->
      (out_r.seconds == '0 && out_r.fraction == '0 && out_r.consumed == 4'd0))
    else $error("error result with nonzero payload");

endmodule

`default_nettype wire
